@@ design/ipid_pkg.sv @@
// Shared types, constants and widths for the incremental PID step block.
`timescale 1ns / 1ps
`default_nettype none

package ipid_pkg;

  // Sizing knobs
  localparam int unsigned SAMPLE_BITS    = 16;
  localparam int unsigned GAIN_FRAC_BITS = 8;

  // Fixed field widths
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned ERR_W     = 18;
  localparam int unsigned INC_OUT_W = 17;
  localparam int unsigned SUM_W     = 18;  // drive + increment, signed
  localparam int unsigned REG_IDX_W = 3;

  // Standard mode: 17-bit signed gain times 18-bit signed error
  localparam int unsigned PROD_W = 35;
  localparam logic signed [PROD_W-1:0] FRAC_BIAS =
    PROD_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

  // Adaptive mode: S = 49e - 70e1 + 25e2, |S| < 2^24
  localparam int unsigned ASUM_W  = 24;
  localparam int unsigned ADP_S_W = ASUM_W + 1;
  localparam logic signed [ADP_S_W-1:0] ADP_C_E  = ADP_S_W'(49);
  localparam logic signed [ADP_S_W-1:0] ADP_C_E1 = ADP_S_W'(70);
  localparam logic signed [ADP_S_W-1:0] ADP_C_E2 = ADP_S_W'(25);

  // kp * |S| scaled by 1 / (20 * 2^F): shift by F+2, then divide by 5
  localparam int unsigned AMAG_W     = DATA_W + ASUM_W;
  localparam int unsigned ADP_SHIFT  = GAIN_FRAC_BITS + 2;
  localparam int unsigned ADP_X_W    = AMAG_W - ADP_SHIFT;
  localparam int unsigned DIV5_SHIFT = ADP_X_W + 3;
  localparam int unsigned DIV5_M_W   = DIV5_SHIFT - 2;
  localparam int unsigned DIV_P_W    = ADP_X_W + DIV5_M_W;
  localparam logic [DIV5_M_W-1:0] DIV5_MULT =
    DIV5_M_W'(((64'd1 << DIV5_SHIFT) + 64'd4) / 64'd5);

  // Unlimited increment width (both modes share it)
  localparam int unsigned INC_W  = 37 - GAIN_FRAC_BITS;
  localparam int unsigned QUOT_W = INC_W - 1;

  localparam logic [DATA_W-1:0] SAMPLE_MASK = (SAMPLE_BITS >= DATA_W) ?
    {DATA_W{1'b1}} : DATA_W'((64'd1 << SAMPLE_BITS) - 64'd1);

  // Register reset values
  localparam logic [DATA_W-1:0] KP_RST         = DATA_W'(512);
  localparam logic [DATA_W-1:0] KI_RST         = DATA_W'(768);
  localparam logic [DATA_W-1:0] KD_RST         = DATA_W'(1280);
  localparam logic [DATA_W-1:0] SETPOINT_RST   = DATA_W'(3000);
  localparam logic [DATA_W-1:0] STEP_LIMIT_RST = DATA_W'(5000);
  localparam logic [DATA_W-1:0] OUT_MAX_RST    = DATA_W'(4095);
  localparam logic [DATA_W-1:0] OUT_MIN_RST    = DATA_W'(0);

  typedef enum logic [0:0] {
    OP_STEP   = 1'b0,
    OP_MANUAL = 1'b1
  } ipid_op_e;

  typedef enum logic [0:0] {
    MODE_ADAPTIVE = 1'b0,
    MODE_STANDARD = 1'b1
  } ipid_mode_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MODE       = 3'd0,
    REG_KP         = 3'd1,
    REG_KI         = 3'd2,
    REG_KD         = 3'd3,
    REG_SETPOINT   = 3'd4,
    REG_STEP_LIMIT = 3'd5,
    REG_OUT_MAX    = 3'd6,
    REG_OUT_MIN    = 3'd7
  } ipid_reg_e;

  // Settings the increment pipeline needs
  typedef struct packed {
    ipid_mode_e        mode;
    logic [DATA_W-1:0] kp;
    logic [DATA_W-1:0] ki;
    logic [DATA_W-1:0] kd;
    logic [DATA_W-1:0] step_limit;
  } ipid_cfg_t;

  // Error stage into the increment pipeline
  typedef struct packed {
    ipid_op_e                op;
    logic [DATA_W-1:0]       manual;
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W-1:0] err1;
    logic signed [ERR_W-1:0] err2;
  } ipid_err_t;

  // Limited increment out of the pipeline
  typedef struct packed {
    ipid_op_e                    op;
    logic [DATA_W-1:0]           manual;
    logic signed [INC_OUT_W-1:0] inc;
    logic                        limited;
  } ipid_inc_t;

endpackage

`default_nettype wire

@@ design/incremental_pid_step_core.sv @@
// Top level of the incremental PID step: registers, error history, drive update.
//
// Usage: one transaction on the input channel (in_valid_i / in_ready_o) carries
// opcode_i, sample_i and manual_value_i. A control step forms the error against
// the setpoint, builds the velocity-form increment, limits it and adds it to the
// drive value; a manual load sets the drive directly. Every input transaction
// yields exactly one result transaction (out_valid_o / out_ready_i) with
// drive_o, increment_o and step_limited_o, in order.
// Path: the error register loads at the accepting edge, then four increment stages
// and the drive register follow. Throughput: one transaction per cycle while
// out_ready_i is high; the drive accumulator closes its loop within the last stage.
// Settings go in through cfg_we_i / cfg_index_i / cfg_data_i, one register per cycle;
// users must write them only with no transaction in flight; the block does not enforce it.
// Reset: registers return to their defaults, the error history and the drive
// value clear to zero, and all stages empty.
// Stall: when out_ready_i is low the result holds; inner stages keep filling
// until every stage is full, and only then does in_ready_o drop.
`timescale 1ns / 1ps
`default_nettype none

module incremental_pid_step_core (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // input channel
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic                                  opcode_i,
  input  wire logic [ipid_pkg::DATA_W-1:0]           sample_i,
  input  wire logic [ipid_pkg::DATA_W-1:0]           manual_value_i,
  // result channel
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic [ipid_pkg::DATA_W-1:0]                drive_o,
  output logic signed [ipid_pkg::INC_OUT_W-1:0]      increment_o,
  output logic                                       step_limited_o,
  // register write port
  input  wire logic                                  cfg_we_i,
  input  wire logic [ipid_pkg::REG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [ipid_pkg::DATA_W-1:0]           cfg_data_i
);

  ipid_pkg::ipid_mode_e        mode_q;
  logic [ipid_pkg::DATA_W-1:0] kp_q, ki_q, kd_q, setpoint_q;
  logic [ipid_pkg::DATA_W-1:0] step_limit_q, out_max_q, out_min_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ipid_pkg::MODE_ADAPTIVE;
      kp_q         <= ipid_pkg::KP_RST;
      ki_q         <= ipid_pkg::KI_RST;
      kd_q         <= ipid_pkg::KD_RST;
      setpoint_q   <= ipid_pkg::SETPOINT_RST;
      step_limit_q <= ipid_pkg::STEP_LIMIT_RST;
      out_max_q    <= ipid_pkg::OUT_MAX_RST;
      out_min_q    <= ipid_pkg::OUT_MIN_RST;
    end else if (cfg_we_i) begin
      unique case (ipid_pkg::ipid_reg_e'(cfg_index_i))
        ipid_pkg::REG_MODE:       mode_q       <= ipid_pkg::ipid_mode_e'(cfg_data_i[0]);
        ipid_pkg::REG_KP:         kp_q         <= cfg_data_i;
        ipid_pkg::REG_KI:         ki_q         <= cfg_data_i;
        ipid_pkg::REG_KD:         kd_q         <= cfg_data_i;
        ipid_pkg::REG_SETPOINT:   setpoint_q   <= cfg_data_i;
        ipid_pkg::REG_STEP_LIMIT: step_limit_q <= cfg_data_i;
        ipid_pkg::REG_OUT_MAX:    out_max_q    <= cfg_data_i;
        ipid_pkg::REG_OUT_MIN:    out_min_q    <= cfg_data_i;
      endcase
    end
  end

  ipid_pkg::ipid_cfg_t pipe_cfg;
  assign pipe_cfg = '{mode: mode_q, kp: kp_q, ki: ki_q, kd: kd_q, step_limit: step_limit_q};

  // Error stage and history
  logic                                 a_valid_q, pipe_in_ready, in_accept;
  ipid_pkg::ipid_err_t                  a_q;
  ipid_pkg::ipid_op_e                   in_op;
  logic signed [ipid_pkg::ERR_W-1:0]    err_new, last_err_q, prior_err_q;
  logic [ipid_pkg::DATA_W-1:0]          sample_m;

  assign in_op      = ipid_pkg::ipid_op_e'(opcode_i);
  assign sample_m   = sample_i & ipid_pkg::SAMPLE_MASK;
  assign err_new    = $signed({2'b00, setpoint_q}) - $signed({2'b00, sample_m});
  assign in_ready_o = !a_valid_q || pipe_in_ready;
  assign in_accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      last_err_q  <= '0;
      prior_err_q <= '0;
    end else begin
      if (in_ready_o) a_valid_q <= in_valid_i;
      if (in_accept && in_op == ipid_pkg::OP_STEP) begin
        prior_err_q <= last_err_q;
        last_err_q  <= err_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_q <= '{op: in_op, manual: manual_value_i, err: err_new,
               err1: last_err_q, err2: prior_err_q};
    end
  end

  // Increment pipeline
  logic                pipe_out_valid, out_ready_int;
  ipid_pkg::ipid_inc_t pipe_out;

  ipid_incr_pipe u_incr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (pipe_cfg),
    .in_valid_i  (a_valid_q),
    .in_ready_o  (pipe_in_ready),
    .in_data_i   (a_q),
    .out_valid_o (pipe_out_valid),
    .out_ready_i (out_ready_int),
    .out_data_o  (pipe_out)
  );

  // Drive update: add increment (or take manual value), clamp high then low
  logic signed [ipid_pkg::SUM_W-1:0] drive_sum, drive_hi, max_ext, min_ext;
  logic [ipid_pkg::DATA_W-1:0]       drive_d;
  always_comb begin
    max_ext = $signed({2'b00, out_max_q});
    min_ext = $signed({2'b00, out_min_q});
    if (pipe_out.op == ipid_pkg::OP_MANUAL) begin
      drive_sum = $signed({2'b00, pipe_out.manual});
    end else begin
      drive_sum = $signed({2'b00, drive_o})
                + ipid_pkg::SUM_W'($signed(pipe_out.inc));
    end
    drive_hi = (drive_sum > max_ext) ? max_ext : drive_sum;
    drive_d  = (drive_hi < min_ext) ? out_min_q : drive_hi[ipid_pkg::DATA_W-1:0];
  end

  // Result register; drive_o doubles as the drive accumulator
  ipid_pkg::ipid_op_e out_op_q;
  assign out_ready_int = !out_valid_o || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
      drive_o     <= '0;
    end else if (out_ready_int) begin
      out_valid_o <= pipe_out_valid;
      if (pipe_out_valid) drive_o <= drive_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready_int && pipe_out_valid) begin
      increment_o    <= pipe_out.inc;
      step_limited_o <= pipe_out.limited;
      out_op_q       <= pipe_out.op;
    end
  end

  // Manual loads report no increment
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_op_q == ipid_pkg::OP_MANUAL |-> increment_o == '0 && !step_limited_o)
    else $error("manual load reported an increment");

  // A limited increment sits exactly on the step limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && step_limited_o |->
      (increment_o == $signed({1'b0, step_limit_q}))
      || (increment_o == -$signed({1'b0, step_limit_q})))
    else $error("limited increment not at the step limit");

  // Error history shifts on every accepted control step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_op == ipid_pkg::OP_STEP |=>
      prior_err_q == $past(last_err_q) && last_err_q == $past(err_new))
    else $error("error history did not shift");

endmodule

`default_nettype wire

@@ design/ipid_incr_pipe.sv @@
// Pipelined increment datapath: products, scaling, mode select and step limit.
`timescale 1ns / 1ps
`default_nettype none

module ipid_incr_pipe (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ipid_pkg::ipid_cfg_t  cfg_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire ipid_pkg::ipid_err_t  in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output ipid_pkg::ipid_inc_t       out_data_o
);

  typedef struct packed {
    ipid_pkg::ipid_op_e                          op;
    logic [ipid_pkg::DATA_W-1:0]                 manual;
    logic signed [ipid_pkg::PROD_W-1:0]          kp_e;
    logic signed [ipid_pkg::PROD_W-1:0]          ki_e1;
    logic signed [ipid_pkg::PROD_W-1:0]          kd_e2;
    logic                                        s_neg;
    logic [ipid_pkg::ASUM_W-1:0]                 s_mag;
  } prod_t;

  typedef struct packed {
    ipid_pkg::ipid_op_e                          op;
    logic [ipid_pkg::DATA_W-1:0]                 manual;
    logic signed [ipid_pkg::INC_W-1:0]           inc_std;
    logic                                        adp_neg;
    logic [ipid_pkg::ADP_X_W-1:0]                adp_x;
  } scale_t;

  typedef struct packed {
    ipid_pkg::ipid_op_e                          op;
    logic [ipid_pkg::DATA_W-1:0]                 manual;
    logic signed [ipid_pkg::INC_W-1:0]           inc_std;
    logic                                        adp_neg;
    logic [ipid_pkg::QUOT_W-1:0]                 quot;
  } quot_t;

  // Divide by 2^F, truncating toward zero
  function automatic logic signed [ipid_pkg::INC_W-1:0] trunc_frac(
    input logic signed [ipid_pkg::PROD_W-1:0] x
  );
    logic signed [ipid_pkg::PROD_W-1:0] biased;
    biased = x[ipid_pkg::PROD_W-1] ? x + ipid_pkg::FRAC_BIAS : x;
    return ipid_pkg::INC_W'(biased >>> ipid_pkg::GAIN_FRAC_BITS);
  endfunction

  logic   b_valid_q, c_valid_q, d_valid_q, e_valid_q;
  logic   c_ready, d_ready, e_ready;
  prod_t  b_d, b_q;
  scale_t c_d, c_q;
  quot_t  d_d, d_q;
  ipid_pkg::ipid_inc_t e_d, e_q;

  // Stall chain: a stage takes new data when empty or when draining
  assign e_ready    = !e_valid_q || out_ready_i;
  assign d_ready    = !d_valid_q || e_ready;
  assign c_ready    = !c_valid_q || d_ready;
  assign in_ready_o = !b_valid_q || c_ready;

  // Stage B: gain products and adaptive weighted sum
  logic signed [ipid_pkg::ADP_S_W-1:0] adp_s, adp_abs;
  always_comb begin
    adp_s = ipid_pkg::ADP_S_W'($signed(in_data_i.err)) * ipid_pkg::ADP_C_E
          - ipid_pkg::ADP_S_W'($signed(in_data_i.err1)) * ipid_pkg::ADP_C_E1
          + ipid_pkg::ADP_S_W'($signed(in_data_i.err2)) * ipid_pkg::ADP_C_E2;
    adp_abs = adp_s[ipid_pkg::ADP_S_W-1] ? -adp_s : adp_s;
    b_d.op     = in_data_i.op;
    b_d.manual = in_data_i.manual;
    b_d.kp_e   = ipid_pkg::PROD_W'($signed({1'b0, cfg_i.kp}))
               * ipid_pkg::PROD_W'($signed(in_data_i.err));
    b_d.ki_e1  = ipid_pkg::PROD_W'($signed({1'b0, cfg_i.ki}))
               * ipid_pkg::PROD_W'($signed(in_data_i.err1));
    b_d.kd_e2  = ipid_pkg::PROD_W'($signed({1'b0, cfg_i.kd}))
               * ipid_pkg::PROD_W'($signed(in_data_i.err2));
    b_d.s_neg  = adp_s[ipid_pkg::ADP_S_W-1];
    b_d.s_mag  = adp_abs[ipid_pkg::ASUM_W-1:0];
  end

  // Stage C: standard sum of truncated terms, adaptive kp * |S|
  logic [ipid_pkg::AMAG_W-1:0] adp_mag;
  always_comb begin
    adp_mag     = ipid_pkg::AMAG_W'(cfg_i.kp) * ipid_pkg::AMAG_W'(b_q.s_mag);
    c_d.op      = b_q.op;
    c_d.manual  = b_q.manual;
    c_d.inc_std = trunc_frac(b_q.kp_e) - trunc_frac(b_q.ki_e1) + trunc_frac(b_q.kd_e2);
    c_d.adp_neg = b_q.s_neg;
    c_d.adp_x   = adp_mag[ipid_pkg::AMAG_W-1:ipid_pkg::ADP_SHIFT];
  end

  // Stage D: divide by five through a reciprocal multiply (exact over this range)
  logic [ipid_pkg::DIV_P_W-1:0] div_prod;
  always_comb begin
    div_prod    = ipid_pkg::DIV_P_W'(c_q.adp_x) * ipid_pkg::DIV_P_W'(ipid_pkg::DIV5_MULT);
    d_d.op      = c_q.op;
    d_d.manual  = c_q.manual;
    d_d.inc_std = c_q.inc_std;
    d_d.adp_neg = c_q.adp_neg;
    d_d.quot    = div_prod[ipid_pkg::DIV_P_W-1:ipid_pkg::DIV5_SHIFT];
  end

  // Stage E: mode select and step limit; manual loads carry no increment
  logic signed [ipid_pkg::INC_W-1:0] adp_pos, inc_sel, lim;
  always_comb begin
    adp_pos = $signed({1'b0, d_q.quot});
    lim     = ipid_pkg::INC_W'($signed({1'b0, cfg_i.step_limit}));
    if (cfg_i.mode == ipid_pkg::MODE_STANDARD) begin
      inc_sel = d_q.inc_std;
    end else begin
      inc_sel = d_q.adp_neg ? -adp_pos : adp_pos;
    end
    e_d.op      = d_q.op;
    e_d.manual  = d_q.manual;
    e_d.limited = 1'b0;
    priority if (d_q.op == ipid_pkg::OP_MANUAL) begin
      e_d.inc = '0;
    end else if (inc_sel > lim) begin
      e_d.inc     = ipid_pkg::INC_OUT_W'(lim);
      e_d.limited = 1'b1;
    end else if (inc_sel < -lim) begin
      e_d.inc     = ipid_pkg::INC_OUT_W'(-lim);
      e_d.limited = 1'b1;
    end else begin
      e_d.inc = ipid_pkg::INC_OUT_W'(inc_sel);
    end
  end

  // Stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) b_valid_q <= in_valid_i;
      if (c_ready)    c_valid_q <= b_valid_q;
      if (d_ready)    d_valid_q <= c_valid_q;
      if (e_ready)    e_valid_q <= d_valid_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) b_q <= b_d;
    if (c_ready && b_valid_q)     c_q <= c_d;
    if (d_ready && c_valid_q)     d_q <= d_d;
    if (e_ready && d_valid_q)     e_q <= e_d;
  end

  assign out_valid_o = e_valid_q;
  assign out_data_o  = e_q;

  // A waiting increment never exceeds the step limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_valid_q |-> ($signed(e_q.inc) <= $signed({1'b0, cfg_i.step_limit}))
               && ($signed(e_q.inc) >= -$signed({1'b0, cfg_i.step_limit})))
    else $error("limited increment out of range");

  // A stalled last stage keeps its transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_valid_q && !out_ready_i |=> e_valid_q && $stable(e_q))
    else $error("last stage lost or changed a stalled transaction");

  // A manual load leaves the last stage with no increment
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_valid_q && e_q.op == ipid_pkg::OP_MANUAL |-> e_q.inc == '0 && !e_q.limited)
    else $error("manual load carries an increment");

endmodule

`default_nettype wire
